/* design/tcspq_pkg.sv */
// ----------------------------------------------------------------------------
// tcspq_pkg
// Shared types and constants of the two-class sorted priority queue: the
// record layout, command and status codes, and the per-cell control group.
// ----------------------------------------------------------------------------
package tcspq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int COUNT_OUT_W     = 5;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic               urgent;
        logic [15:0]        app;
        logic [31:0]        tn;
        logic signed [15:0] sql;
    } t_record;

    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctrl;

endpackage

/* design/tcspq_cell.sv */
// ----------------------------------------------------------------------------
// tcspq_cell
// One slot of the queue. Compares the broadcast record against its own,
// tells its right neighbor whether the new record lands at or before it,
// and shifts right on insert or left on remove.
// ----------------------------------------------------------------------------
module tcspq_cell
    import tcspq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_record    i_new_rec,
    input  t_record    i_left_rec,
    input  logic       i_left_valid,
    input  logic       i_left_place,
    input  t_record    i_right_rec,
    input  logic       i_right_valid,
    output t_record    o_rec,
    output logic       o_valid,
    output logic       o_place
);

    t_record r_rec;
    logic    r_valid;
    t_record n_rec;
    logic    n_valid;
    logic    w_match;

    // urgent goes before the first normal; normal before the first larger number
    assign w_match = r_valid && !r_rec.urgent
                     && (i_new_rec.urgent || (r_rec.tn > i_new_rec.tn));
    assign o_place = w_match || !r_valid;

    always_comb begin
        n_rec   = r_rec;
        n_valid = r_valid;
        if (i_ctrl.insert && o_place) begin
            if (i_left_place) begin
                n_rec   = i_left_rec;
                n_valid = i_left_valid;
            end else begin
                n_rec   = i_new_rec;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.remove) begin
            n_rec   = i_right_rec;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec   = r_rec;
    assign o_valid = r_valid;

endmodule

/* design/two_class_sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// two_class_sorted_priority_queue
// Bounded ordered queue of request records built as a row of compare cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands: tuser holds command and urgency flag, tdata the
//   record. Insert places an urgent record after all held urgent records and
//   a normal record after all urgent records in ascending transaction order,
//   equal numbers in arrival order. Remove pops the head record.
//   Every command gives exactly one beat on m_axis: tuser holds status,
//   out_valid and out_urgent, tdata the removed record and the entry count.
//   One command is taken per cycle while the receiver takes each beat:
//   every cell compares the broadcast record in parallel and shifts in
//   the same edge, and the result sits in an output register.
//   When the receiver stalls, the result register holds and s_axis_tready
//   drops until the beat is taken; a new command is accepted in the same
//   cycle the held beat leaves.
//   Reset (synchronous, active low) empties the queue and the result
//   register; no clearing pass is needed.
//   A full insert returns status full, an empty remove status empty, and
//   the queue is left unchanged.
// ----------------------------------------------------------------------------
module two_class_sorted_priority_queue
    import tcspq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] application_code, [47:16] transaction_number, [63:48] sql_code
    input  logic [63:0] s_axis_tdata,
    // [0] command, [1] urgent
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] out_application_code, [47:16] out_transaction_number,
    // [63:48] out_sql_code, [68:64] entry_count, [71:69] zero
    output logic [71:0] m_axis_tdata,
    // [1:0] status, [2] out_valid, [3] out_urgent
    output logic [3:0]  m_axis_tuser
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_record          w_new_rec;
    t_cmd             w_cmd;
    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    t_cell_ctrl       w_ctrl;

    t_record          w_rec   [QUEUE_DEPTH];
    logic             w_valid [QUEUE_DEPTH];
    logic             w_place [QUEUE_DEPTH];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [31:0]      w_count_ext;

    logic             r_out_valid;
    t_status          r_status;
    logic             r_rec_valid;
    t_record          r_out_rec;
    logic [COUNT_OUT_W-1:0] r_entry_count;
    t_status          n_status;
    logic             n_rec_valid;
    t_record          n_out_rec;

    assign w_cmd            = t_cmd'(s_axis_tuser[0]);
    assign w_new_rec.urgent = s_axis_tuser[1];
    assign w_new_rec.app    = s_axis_tdata[15:0];
    assign w_new_rec.tn     = s_axis_tdata[47:16];
    assign w_new_rec.sql    = s_axis_tdata[63:48];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty       = (r_count == '0);

    assign w_ctrl.insert = w_accept && (w_cmd == CMD_INSERT) && !w_full;
    assign w_ctrl.remove = w_accept && (w_cmd == CMD_REMOVE) && !w_empty;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            t_record w_left_rec;
            logic    w_left_valid;
            logic    w_left_place;
            t_record w_right_rec;
            logic    w_right_valid;

            if (gi == 0) begin : g_head
                assign w_left_rec   = w_new_rec;
                assign w_left_valid = 1'b0;
                assign w_left_place = 1'b0;
            end else begin : g_body
                assign w_left_rec   = w_rec[gi-1];
                assign w_left_valid = w_valid[gi-1];
                assign w_left_place = w_place[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign w_right_rec   = w_rec[gi];
                assign w_right_valid = 1'b0;
            end else begin : g_mid
                assign w_right_rec   = w_rec[gi+1];
                assign w_right_valid = w_valid[gi+1];
            end

            tcspq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_new_rec     (w_new_rec),
                .i_left_rec    (w_left_rec),
                .i_left_valid  (w_left_valid),
                .i_left_place  (w_left_place),
                .i_right_rec   (w_right_rec),
                .i_right_valid (w_right_valid),
                .o_rec         (w_rec[gi]),
                .o_valid       (w_valid[gi]),
                .o_place       (w_place[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_rec_valid = 1'b0;
        n_out_rec   = '0;
        unique case (w_cmd)
            CMD_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count     = r_count - CNT_W'(1);
                    n_rec_valid = 1'b1;
                    n_out_rec   = w_rec[0];
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign w_count_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= n_status;
            r_rec_valid   <= n_rec_valid;
            r_out_rec     <= n_out_rec;
            r_entry_count <= w_count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_entry_count, r_out_rec.sql,
                            r_out_rec.tn, r_out_rec.app};
    assign m_axis_tuser  = {r_out_rec.urgent, r_rec_valid, r_status};

endmodule
